FILE: sv/gsvc_pkg.sv
// ----------------------------------------------------------------------------
// gsvc_pkg
// Shared types and constants for the grid store and value counter.
// ----------------------------------------------------------------------------
package gsvc_pkg;

    // field widths of the command and result items
    localparam int CMD_W   = 2;
    localparam int CRD_W   = 6;
    localparam int VAL_W   = 8;
    localparam int DIR_W   = 2;
    localparam int LEN_W   = 7;
    localparam int RD_W    = 8;
    localparam int CNT_W   = 13;

    // configuration port
    localparam int CFG_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // signed width for line end points: -126 .. 189
    localparam int PT_W    = 9;

    // register reset values
    localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 7'd64;
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE      = 2'd0,
        CMD_READ       = 2'd1,
        CMD_COUNT_ALL  = 2'd2,
        CMD_COUNT_LINE = 2'd3
    } cmd_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_NORTH = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_EAST  = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WRITE,
        ST_WALK,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] row_count;
        logic [CFG_W-1:0] column_count;
    } cfg_t;

endpackage

FILE: sv/gsvc_ram.sv
// ----------------------------------------------------------------------------
// gsvc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gsvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

FILE: sv/gsvc_regs.sv
// ----------------------------------------------------------------------------
// gsvc_regs
// APB register file holding the row and column counts in use.
// ----------------------------------------------------------------------------
module gsvc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [gsvc_pkg::PDATA_W-1:0]  pwdata,
    output logic [gsvc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output gsvc_pkg::cfg_t                cfg
);
    import gsvc_pkg::*;

    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] column_count_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RST;
            column_count_reg <= COLUMN_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ROW_COUNT:    row_count_reg    <= pwdata[CFG_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[CFG_W-1:0];
                default:          row_count_reg    <= row_count_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_sel)
            REG_ROW_COUNT:    prdata = PDATA_W'(row_count_reg);
            REG_COLUMN_COUNT: prdata = PDATA_W'(column_count_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.row_count    = row_count_reg;
    assign cfg.column_count = column_count_reg;

endmodule

FILE: sv/grid_store_value_counter_core.sv
// ----------------------------------------------------------------------------
// grid_store_value_counter_core
// From accept to done a write passes setup, write and result; a read passes
// setup, walk, drain and result; a line or whole-grid count walks its cells
// between setup and drain; an item settled at setup (point or line off the
// grid, empty line, empty grid) goes straight to result. One item at a time,
// set by the single RAM port walked one cell a cycle; done is never held off.
// After reset a clearing pass zeroes all MAX_ROWS*MAX_COLS cells, busy high.
// ----------------------------------------------------------------------------
module grid_store_value_counter_core #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [gsvc_pkg::CMD_W-1:0]    command,
    input  logic [gsvc_pkg::CRD_W-1:0]    x_coord,
    input  logic [gsvc_pkg::CRD_W-1:0]    y_coord,
    input  logic [gsvc_pkg::VAL_W-1:0]    cell_value,
    input  logic [gsvc_pkg::DIR_W-1:0]    direction,
    input  logic [gsvc_pkg::LEN_W-1:0]    line_length,
    // result channel
    output logic                          done,
    output logic [gsvc_pkg::RD_W-1:0]     read_data,
    output logic [gsvc_pkg::CNT_W-1:0]    match_count,
    output logic                          status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [gsvc_pkg::PDATA_W-1:0]  pwdata,
    output logic [gsvc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import gsvc_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t                   cfg;
    state_t                 state_reg, state_next;

    // item registers
    cmd_t                   cmd_reg;
    dir_t                   dir_reg;
    logic [CRD_W-1:0]       x_reg, y_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [LEN_W-1:0]       len_reg;

    // walk control
    logic [AW-1:0]          addr_reg, addr_next;
    logic [AW-1:0]          step;
    logic [CFG_W-1:0]       col_left_reg, col_left_next;
    logic [CFG_W-1:0]       row_left_reg, row_left_next;
    logic                   cmp_pend_reg, cmp_pend_next;
    logic                   walk_last;

    // result registers
    logic [RD_W-1:0]        read_data_reg, read_data_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   status_reg, status_next;

    // bounds
    logic [CFG_W-1:0]       rows_used, cols_used;
    logic signed [PT_W-1:0] s_rows, s_cols, sx, sy, len_m1, end_x, end_y;
    logic                   start_ok, end_ok, accept;
    logic [AW-1:0]          base_addr;

    // memory port
    logic                   ram_en, ram_we;
    logic [VALUE_BITS-1:0]  ram_wdata, ram_rdata;

    gsvc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gsvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept = start & ~busy;

    // grid size in use, saturated at the store size
    assign rows_used = (cfg.row_count > MAX_ROWS) ? CFG_W'(MAX_ROWS) : cfg.row_count;
    assign cols_used = (cfg.column_count > MAX_COLS) ? CFG_W'(MAX_COLS) : cfg.column_count;
    assign s_rows    = PT_W'(rows_used);
    assign s_cols    = PT_W'(cols_used);

    // start point and line end point checks
    assign sx       = PT_W'(x_reg);
    assign sy       = PT_W'(y_reg);
    assign len_m1   = PT_W'(len_reg) - PT_W'(1);
    assign start_ok = (x_reg < cols_used) && (y_reg < rows_used);

    always_comb
    begin
        end_x = sx;
        end_y = sy;
        unique case (dir_reg)
            DIR_NORTH: end_y = sy + len_m1;
            DIR_SOUTH: end_y = sy - len_m1;
            DIR_EAST:  end_x = sx + len_m1;
            DIR_WEST:  end_x = sx - len_m1;
            default:   end_x = sx;
        endcase
    end

    assign end_ok = (end_x >= 0) && (end_y >= 0) && (end_x < s_cols) && (end_y < s_rows);

    // row-major cell address of the start point
    assign base_addr = AW'(int'(y_reg) * MAX_COLS + int'(x_reg));

    // address step of the shared adder
    always_comb
    begin
        step = AW'(1);
        if (state_reg == ST_WALK)
        begin
            unique case (cmd_reg)
                CMD_COUNT_ALL:
                begin
                    if (col_left_reg == '0)
                    begin
                        step = AW'(MAX_COLS - int'(cols_used) + 1);
                    end
                end
                CMD_COUNT_LINE:
                begin
                    unique case (dir_reg)
                        DIR_NORTH: step = AW'(MAX_COLS);
                        DIR_SOUTH: step = AW'(-MAX_COLS);
                        DIR_EAST:  step = AW'(1);
                        DIR_WEST:  step = AW'(-1);
                        default:   step = AW'(1);
                    endcase
                end
                default: step = AW'(1);
            endcase
        end
    end

    assign walk_last = (col_left_reg == '0) &&
                       ((cmd_reg != CMD_COUNT_ALL) || (row_left_reg == '0));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                unique case (cmd_reg)
                    CMD_WRITE:      state_next = start_ok ? ST_WRITE : ST_RESULT;
                    CMD_READ:       state_next = start_ok ? ST_WALK : ST_RESULT;
                    CMD_COUNT_ALL:
                        state_next = (rows_used == '0 || cols_used == '0) ? ST_RESULT
                                                                          : ST_WALK;
                    CMD_COUNT_LINE:
                        state_next = (len_reg == '0 || !(start_ok && end_ok)) ? ST_RESULT
                                                                              : ST_WALK;
                    default:        state_next = ST_RESULT;
                endcase
            end
            ST_WRITE:  state_next = ST_RESULT;
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_RESULT;
            ST_RESULT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        done = (state_reg == ST_RESULT);
    end

    // datapath and memory control
    always_comb
    begin
        addr_next      = addr_reg;
        col_left_next  = col_left_reg;
        row_left_next  = row_left_reg;
        cmp_pend_next  = 1'b0;
        read_data_next = read_data_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = value_reg;

        // compare the cell read in the previous cycle
        if (cmp_pend_reg && (cmd_reg != CMD_READ) && (ram_rdata == value_reg))
        begin
            count_next = count_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = addr_reg + step;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    read_data_next = '0;
                    count_next     = '0;
                    status_next    = 1'b0;
                end
            end
            ST_SETUP:
            begin
                addr_next     = base_addr;
                col_left_next = '0;
                row_left_next = '0;
                unique case (cmd_reg)
                    CMD_WRITE, CMD_READ:
                    begin
                        status_next = !start_ok;
                    end
                    CMD_COUNT_ALL:
                    begin
                        addr_next     = '0;
                        col_left_next = cols_used - CFG_W'(1);
                        row_left_next = rows_used - CFG_W'(1);
                    end
                    CMD_COUNT_LINE:
                    begin
                        col_left_next = len_reg - LEN_W'(1);
                        status_next   = (len_reg != '0) && !(start_ok && end_ok);
                    end
                    default: status_next = 1'b0;
                endcase
            end
            ST_WRITE:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            ST_WALK:
            begin
                ram_en        = 1'b1;
                cmp_pend_next = 1'b1;
                addr_next     = addr_reg + step;
                if (col_left_reg != '0)
                begin
                    col_left_next = col_left_reg - CFG_W'(1);
                end
                else if (row_left_reg != '0)
                begin
                    col_left_next = cols_used - CFG_W'(1);
                    row_left_next = row_left_reg - CFG_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    read_data_next = RD_W'(ram_rdata);
                end
            end
            ST_RESULT: addr_next = addr_reg;
            default:   addr_next = addr_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            cmp_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            cmp_pend_reg <= cmp_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(command);
            dir_reg   <= dir_t'(direction);
            x_reg     <= x_coord;
            y_reg     <= y_coord;
            value_reg <= VALUE_BITS'(cell_value);
            len_reg   <= line_length;
        end
        col_left_reg  <= col_left_next;
        row_left_reg  <= row_left_next;
        read_data_reg <= read_data_next;
        count_reg     <= count_next;
        status_reg    <= status_next;
    end

    assign read_data   = read_data_reg;
    assign match_count = count_reg;
    assign status      = status_reg;

    // checks
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done))
        else $error("result strobe right after an accepted item");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not idle after result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (match_count == '0 && read_data == '0))
        else $error("error result carries data");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("grid written outside clear or write phase");

    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && cmd_reg == CMD_READ) |=> (state_reg == ST_DRAIN))
        else $error("read walks more than one cell");

endmodule

FILE: verif/gsvc_grid_checker.sv
// ----------------------------------------------------------------------------
// gsvc_grid_checker
// Watches the command, result and register channels of the grid store and
// value counter, keeps its own copy of the grid and the row and column
// settings, works out the reply to every accepted item and compares each
// reply strobe against the oldest awaited one. Register reads are checked
// against the settings last written.
// ----------------------------------------------------------------------------
module gsvc_grid_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    input  logic                          busy,
    input  logic [gsvc_pkg::CMD_W-1:0]    command,
    input  logic [gsvc_pkg::CRD_W-1:0]    x_coord,
    input  logic [gsvc_pkg::CRD_W-1:0]    y_coord,
    input  logic [gsvc_pkg::VAL_W-1:0]    cell_value,
    input  logic [gsvc_pkg::DIR_W-1:0]    direction,
    input  logic [gsvc_pkg::LEN_W-1:0]    line_length,
    // result channel
    input  logic                          done,
    input  logic [gsvc_pkg::RD_W-1:0]     read_data,
    input  logic [gsvc_pkg::CNT_W-1:0]    match_count,
    input  logic                          status,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [gsvc_pkg::PDATA_W-1:0]  pwdata,
    input  logic [gsvc_pkg::PDATA_W-1:0]  prdata,
    input  logic                          pready,
    // summary towards the test top
    output int                            pending,
    output int                            fails,
    output int                            checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import gsvc_pkg::*;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    typedef struct packed {
        logic [RD_W-1:0]  read_data;
        logic [CNT_W-1:0] match_count;
        logic             status;
    } grid_reply_t;

    logic [VAL_W-1:0] cells [GRID_ROWS*GRID_COLS];
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    grid_reply_t      awaited_replies [$];

    // settings above the grid size saturate
    function automatic int rows_in_use();
        return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
    endfunction

    function automatic int cols_in_use();
        return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
    endfunction

    function automatic bit in_grid(int x, int y);
        return x >= 0 && y >= 0 && x < cols_in_use() && y < rows_in_use();
    endfunction

    // carries out one command on the grid copy and returns its reply
    function automatic grid_reply_t apply_command(cmd_t cmd, int x, int y,
                                                  logic [VAL_W-1:0] v, dir_t dir,
                                                  int len);
        grid_reply_t reply;
        int dx;
        int dy;
        reply = '0;
        dx = 0;
        dy = 0;
        case (cmd)
            CMD_WRITE:
            begin
                if (in_grid(x, y))
                    cells[y*GRID_COLS + x] = v;
                else
                    reply.status = 1'b1;
            end
            CMD_READ:
            begin
                if (in_grid(x, y))
                    reply.read_data = cells[y*GRID_COLS + x];
                else
                    reply.status = 1'b1;
            end
            CMD_COUNT_ALL:
            begin
                for (int r = 0; r < rows_in_use(); r++)
                    for (int c = 0; c < cols_in_use(); c++)
                        if (cells[r*GRID_COLS + c] == v)
                            reply.match_count++;
            end
            default:
            begin
                case (dir)
                    DIR_NORTH: dy = 1;
                    DIR_SOUTH: dy = -1;
                    DIR_EAST:  dx = 1;
                    default:   dx = -1;
                endcase
                // an empty line is valid wherever it starts
                if (len > 0 && !(in_grid(x, y) &&
                                 in_grid(x + dx*(len-1), y + dy*(len-1))))
                    reply.status = 1'b1;
                else
                    for (int i = 0; i < len; i++)
                        if (cells[(y + dy*i)*GRID_COLS + x + dx*i] == v)
                            reply.match_count++;
            end
        endcase
        return reply;
    endfunction

    // field by field comparison of one reply
    task automatic compare_reply(grid_reply_t want);
        if (read_data !== want.read_data)
        begin
            $error("read_data: expected %0d, got %0d", want.read_data, read_data);
            fails++;
        end
        if (match_count !== want.match_count)
        begin
            $error("match_count: expected %0d, got %0d", want.match_count, match_count);
            fails++;
        end
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [PDATA_W-1:0] reg_want;
        grid_reply_t        fresh_reply;
        if (!rst_n)
        begin
            foreach (cells[i])
                cells[i] = '0;
            rows_reg = ROW_COUNT_RST;
            cols_reg = COLUMN_COUNT_RST;
            awaited_replies.delete();
            pending = 0;
            fails   = 0;
            checked = 0;
        end
        else
        begin
            // register access phase
            if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)
            begin
                if (pwrite === 1'b1)
                begin
                    if (paddr[2] == REG_ROW_COUNT)
                        rows_reg = pwdata[CFG_W-1:0];
                    else
                        cols_reg = pwdata[CFG_W-1:0];
                end
                else
                begin
                    reg_want = '0;
                    reg_want[CFG_W-1:0] = (paddr[2] == REG_ROW_COUNT) ? rows_reg : cols_reg;
                    if (prdata !== reg_want)
                    begin
                        $error("prdata: expected %0d, got %0d", reg_want, prdata);
                        fails++;
                    end
                end
            end
            // reply strobe, taken before any item accepted on the same edge
            if (done === 1'b1)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("done: expected no reply, got one (read_data %0d match_count %0d status %0d)",
                           read_data, match_count, status);
                    fails++;
                end
                else
                begin
                    compare_reply(awaited_replies.pop_front());
                    checked++;
                end
            end
            // accepted item
            if (start === 1'b1 && busy === 1'b0)
            begin
                fresh_reply = apply_command(cmd_t'(command), int'(x_coord),
                                            int'(y_coord), cell_value,
                                            dir_t'(direction), int'(line_length));
                awaited_replies.insert(awaited_replies.size(), fresh_reply);
            end
            pending = awaited_replies.size();
        end
    end

endmodule

FILE: verif/grid_store_value_counter_core_test.sv
// ----------------------------------------------------------------------------
// grid_store_value_counter_core_test
// Drives the grid store and value counter with a directed set of writes,
// reads and counts at the grid corners and edges, then with random commands
// over a series of row and column settings, zero and saturating ones among
// them. A checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module grid_store_value_counter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsvc_pkg::*;

    localparam int CYCLE_LIMIT  = 12_000_000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 10;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   command;
    logic [CRD_W-1:0]   x_coord;
    logic [CRD_W-1:0]   y_coord;
    logic [VAL_W-1:0]   cell_value;
    logic [DIR_W-1:0]   direction;
    logic [LEN_W-1:0]   line_length;
    logic               done;
    logic [RD_W-1:0]    read_data;
    logic [CNT_W-1:0]   match_count;
    logic               status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int pending;
    int fails;
    int checked;
    int cycles;
    int rows_set;
    int cols_set;
    int settings_done;
    int reg_reads;
    int sent [4];

    grid_store_value_counter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .cell_value  (cell_value),
        .direction   (direction),
        .line_length (line_length),
        .done        (done),
        .read_data   (read_data),
        .match_count (match_count),
        .status      (status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    gsvc_grid_checker grid_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .cell_value  (cell_value),
        .direction   (direction),
        .line_length (line_length),
        .done        (done),
        .read_data   (read_data),
        .match_count (match_count),
        .status      (status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pending     (pending),
        .fails       (fails),
        .checked     (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("grid_store_value_counter_core_test: FAIL");
        $finish;
    end

    // presents one item and holds it until the block takes it
    task automatic issue(cmd_t cmd, int x, int y, int v, dir_t dir, int len);
        start       <= 1'b1;
        command     <= cmd;
        x_coord     <= x[CRD_W-1:0];
        y_coord     <= y[CRD_W-1:0];
        cell_value  <= v[VAL_W-1:0];
        direction   <= dir;
        line_length <= len[LEN_W-1:0];
        sent[cmd]++;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // random gap after an item: mostly none, a few long
    task automatic rest();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every awaited reply has come and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // one register write in setup and access cycles, then a read back
    task automatic reg_access(logic idx, int value);
        logic [PDATA_W-1:0] upper;
        upper = $urandom_range(0, 1) ? PDATA_W'($urandom) : '0;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {upper[PDATA_W-1:CFG_W], value[CFG_W-1:0]};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_reads++;
    endtask

    // new grid size, only while the block is idle
    task automatic set_grid(int rows, int cols);
        drain();
        repeat (4) @(posedge clk);
        reg_access(REG_ROW_COUNT, rows);
        reg_access(REG_COLUMN_COUNT, cols);
        rows_set = rows;
        cols_set = cols;
        settings_done++;
    endtask

    function automatic int rows_used();
        return (rows_set > 64) ? 64 : rows_set;
    endfunction

    function automatic int cols_used();
        return (cols_set > 64) ? 64 : cols_set;
    endfunction

    // mostly inside the grid in use, some anywhere in the field
    function automatic int pick_coord(int used);
        if (used > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(0, used - 1);
        return $urandom_range(0, 63);
    endfunction

    // a small set of values keeps the counts non-trivial
    function automatic int pick_value();
        int palette [4] = '{8'h00, 8'hFF, 8'h5A, 8'h01};
        if ($urandom_range(0, 9) < 6)
            return palette[$urandom_range(0, 3)];
        return $urandom_range(0, 255);
    endfunction

    // line length around the reach left to the grid edge
    function automatic int pick_length(int x, int y, dir_t dir);
        int reach;
        int len;
        case (dir)
            DIR_NORTH: reach = rows_used() - y;
            DIR_SOUTH: reach = (y < rows_used()) ? y + 1 : 0;
            DIR_EAST:  reach = cols_used() - x;
            default:   reach = (x < cols_used()) ? x + 1 : 0;
        endcase
        if (x >= cols_used() || y >= rows_used())
            reach = 0;
        case ($urandom_range(0, 9))
            0:       len = 0;
            7:       len = reach;
            8:       len = reach + 1;
            9:       len = $urandom_range(0, 127);
            default: len = (reach > 0) ? $urandom_range(1, reach) : $urandom_range(1, 64);
        endcase
        return (len > 127) ? 127 : len;
    endfunction

    task automatic random_item();
        int   pick;
        int   x;
        int   y;
        dir_t dir;
        pick = $urandom_range(0, 99);
        x    = pick_coord(cols_used());
        y    = pick_coord(rows_used());
        dir  = dir_t'($urandom_range(0, 3));
        if (pick < 40)
            issue(CMD_WRITE, x, y, pick_value(), dir, $urandom_range(0, 127));
        else if (pick < 65)
            issue(CMD_READ, x, y, pick_value(), dir, $urandom_range(0, 127));
        else if (pick < 92)
            issue(CMD_COUNT_LINE, x, y, pick_value(), dir, pick_length(x, y, dir));
        else
            issue(CMD_COUNT_ALL, x, y, pick_value(), dir, $urandom_range(0, 127));
        rest();
    endtask

    // stimulus and verdict
    initial
    begin
        int phase_rows [PHASES];
        int phase_cols [PHASES];
        phase_rows  = '{1, 1, 64, 7, 127, 20, 33, 0, 64, 0};
        phase_cols  = '{1, 64, 1, 9, 3, 40, 50, 5, 64, 0};
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_WRITE;
        x_coord     = '0;
        y_coord     = '0;
        cell_value  = '0;
        direction   = DIR_NORTH;
        line_length = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rows_set      = 64;
        cols_set      = 64;
        settings_done = 0;
        reg_reads     = 0;
        sent          = '{0, 0, 0, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // corners and edges of the full grid, straight after the clearing pass
        issue(CMD_COUNT_ALL,  0,  0, 8'h00, DIR_NORTH, 0);
        issue(CMD_WRITE,      0,  0, 8'hFF, DIR_NORTH, 0);
        issue(CMD_WRITE,     63, 63, 8'hAA, DIR_SOUTH, 0);
        issue(CMD_WRITE,     63,  0, 8'h55, DIR_EAST,  0);
        issue(CMD_WRITE,      0, 63, 8'h01, DIR_WEST,  0);
        issue(CMD_READ,       0,  0, 8'h00, DIR_NORTH, 0);
        issue(CMD_READ,      63, 63, 8'h00, DIR_NORTH, 0);
        issue(CMD_READ,      17, 42, 8'h00, DIR_NORTH, 0);
        issue(CMD_COUNT_LINE, 0,  0, 8'h00, DIR_EAST,  64);
        issue(CMD_COUNT_LINE, 0,  0, 8'hFF, DIR_NORTH, 64);
        issue(CMD_COUNT_LINE, 63, 63, 8'hAA, DIR_SOUTH, 64);
        issue(CMD_COUNT_LINE, 63, 63, 8'h00, DIR_WEST, 65);
        issue(CMD_COUNT_LINE, 40, 40, 8'h00, DIR_NORTH, 0);
        issue(CMD_COUNT_LINE, 5,  5, 8'h00, DIR_EAST,  127);
        issue(CMD_COUNT_ALL,  0,  0, 8'hFF, DIR_NORTH, 0);

        // reduced grid: points and lines off its edges
        set_grid(10, 12);
        issue(CMD_WRITE,     12,  0, 8'h77, DIR_NORTH, 0);
        issue(CMD_READ,       0, 10, 8'h00, DIR_NORTH, 0);
        issue(CMD_COUNT_LINE, 11,  9, 8'h00, DIR_WEST, 12);
        issue(CMD_COUNT_LINE, 11,  9, 8'h00, DIR_EAST, 2);
        issue(CMD_COUNT_ALL,  0,  0, 8'h00, DIR_NORTH, 0);
        issue(CMD_READ,      63, 63, 8'h00, DIR_NORTH, 0);

        // no rows at all
        set_grid(0, 12);
        issue(CMD_COUNT_ALL,  0,  0, 8'h00, DIR_NORTH, 0);
        issue(CMD_WRITE,      0,  0, 8'h33, DIR_NORTH, 0);

        // oversized settings saturate, old cells are back in use
        set_grid(127, 127);
        issue(CMD_READ,      63, 63, 8'h00, DIR_NORTH, 0);
        issue(CMD_COUNT_LINE, 63,  0, 8'h55, DIR_NORTH, 64);

        // random commands over a run of grid sizes
        phase_rows[PHASES-1] = $urandom_range(1, 64);
        phase_cols[PHASES-1] = $urandom_range(1, 64);
        for (int p = 0; p < PHASES; p++)
        begin
            set_grid(phase_rows[p], phase_cols[p]);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                random_item();
                // occasional full pause until all replies are in
                if (n == 30 || $urandom_range(0, 99) < 2)
                    drain();
            end
        end

        // let the last replies arrive, then a short quiet spell
        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d items: %0d writes, %0d reads, %0d grid counts, %0d line counts",
                 sent[CMD_WRITE] + sent[CMD_READ] + sent[CMD_COUNT_ALL] + sent[CMD_COUNT_LINE],
                 sent[CMD_WRITE], sent[CMD_READ], sent[CMD_COUNT_ALL], sent[CMD_COUNT_LINE]);
        $display("%0d replies checked over %0d grid settings, %0d register read-backs",
                 checked, settings_done, reg_reads);
        if (fails == 0)
            $display("grid_store_value_counter_core_test: PASS");
        else
            $display("grid_store_value_counter_core_test: FAIL");
        $finish;
    end

endmodule
